// File: rtl/cpsat_pkg.sv
// Shared types and constants for the two-polygon separating-axis test.
// Used by the top level and its checker; depends on nothing.
package cpsat_pkg;

    localparam int MAX_VERTS  = 16;
    localparam int COORD_BITS = 16;

    localparam int FIELD_W  = 16;
    localparam int CW       = (COORD_BITS < FIELD_W) ? COORD_BITS : FIELD_W;
    localparam int ENTRY_W  = 2 * CW;
    localparam int AXW      = CW + 1;
    localparam int PRW      = 2 * CW + 1;
    localparam int DOTW     = 2 * CW + 2;
    localparam int CNT_W    = $clog2(MAX_VERTS + 1);
    localparam int IDX_W    = $clog2(MAX_VERTS);

    localparam int S_DATA_W = 2 * FIELD_W;
    localparam int S_USER_W = 2;
    localparam int M_DATA_W = 8;
    localparam int M_USER_W = 2;

    typedef enum logic [1:0] {
        CMD_APPEND_A = 2'd0,
        CMD_APPEND_B = 2'd1,
        CMD_RUN      = 2'd2
    } cmd_t;

    typedef enum logic [1:0] {
        STATUS_OK       = 2'd0,
        STATUS_EMPTY    = 2'd1,
        STATUS_OVERFLOW = 2'd2
    } status_t;

endpackage

// File: rtl/convex_polygon_sat_intersect.sv
// Top level of the two-polygon separating-axis intersection test.
// Holds both vertex stores, the sequencer and the shared multiplier; uses cpsat_pkg.
//
//  channel  dir  tdata                        tuser
//  s_       in   vertex_x [15:0], vertex_y    command [1:0]
//                [31:16]
//  m_       out  intersects [0], zero pad     status [1:0]
//
// The one multiplier is used twice per projected vertex of a run.
// Reset clears counts and flags; the stores need no clearing.
// The result waits in an output register; a stalled result only holds the next run's end.
module convex_polygon_sat_intersect (
    input  logic                          aclk,
    input  logic                          aresetn,
    input  logic                          s_tvalid,
    output logic                          s_tready,
    input  logic [cpsat_pkg::S_DATA_W-1:0] s_tdata,  // vertex_x, vertex_y
    input  logic [cpsat_pkg::S_USER_W-1:0] s_tuser,  // command
    output logic                          m_tvalid,
    input  logic                          m_tready,
    output logic [cpsat_pkg::M_DATA_W-1:0] m_tdata,  // intersects, zero pad
    output logic [cpsat_pkg::M_USER_W-1:0] m_tuser   // status
);
    import cpsat_pkg::*;

    typedef enum logic [9:0] {
        ST_IDLE   = 10'b00_0000_0001,
        ST_RD_P   = 10'b00_0000_0010,
        ST_RD_Q   = 10'b00_0000_0100,
        ST_AXIS   = 10'b00_0000_1000,
        ST_RD_V   = 10'b00_0001_0000,
        ST_MUL_X  = 10'b00_0010_0000,
        ST_MUL_Y  = 10'b00_0100_0000,
        ST_CMP    = 10'b00_1000_0000,
        ST_TEST   = 10'b01_0000_0000,
        ST_FINISH = 10'b10_0000_0000
    } state_t;

    state_t state_reg, state_next;

    logic [ENTRY_W-1:0] mem_a [MAX_VERTS];
    logic [ENTRY_W-1:0] mem_b [MAX_VERTS];
    logic [ENTRY_W-1:0] rdata_a_reg, rdata_b_reg;
    logic               rsel_reg;

    logic [CNT_W-1:0] cnt_a_reg, cnt_a_next, cnt_b_reg, cnt_b_next;
    logic             ovf_reg, ovf_next;
    logic             edge_sel_reg, edge_sel_next;
    logic             proj_sel_reg, proj_sel_next;
    logic [IDX_W-1:0] k_reg, k_next, v_reg, v_next;

    logic signed [CW-1:0]   px_reg, px_next, py_reg, py_next;
    logic signed [AXW-1:0]  ax_reg, ax_next, ay_reg, ay_next;
    logic signed [PRW-1:0]  prod_reg, prod_next;
    logic signed [DOTW-1:0] dot_reg, dot_next;
    logic signed [DOTW-1:0] min_a_reg, min_a_next, max_a_reg, max_a_next;
    logic signed [DOTW-1:0] min_b_reg, min_b_next, max_b_reg, max_b_next;

    logic    hit_reg, hit_next;
    status_t status_reg, status_next;
    logic    out_valid_reg, out_valid_next;
    logic    out_hit_reg, out_hit_next;
    status_t out_status_reg, out_status_next;

    logic             s_beat, wr_a, wr_b;
    logic [IDX_W-1:0] rd_addr;
    logic             rd_sel;
    logic [ENTRY_W-1:0] rdata;
    logic signed [CW-1:0]  rd_x, rd_y, mul_a;
    logic signed [AXW-1:0] mul_b;
    logic signed [PRW-1:0] mul_p;
    logic [CNT_W-1:0] cnt_a_m1, cnt_b_m1;
    logic [IDX_W-1:0] last_a, last_b, last_e, last_v, p_idx;
    logic [ENTRY_W-1:0] s_entry;
    logic             first_v, separated;

    assign s_tready = (state_reg == ST_IDLE);
    assign s_beat   = s_tvalid && s_tready;
    assign m_tvalid = out_valid_reg;
    assign m_tdata  = {{(M_DATA_W - 1){1'b0}}, out_hit_reg};
    assign m_tuser  = out_status_reg;

    assign s_entry = {s_tdata[FIELD_W+CW-1:FIELD_W], s_tdata[CW-1:0]};

    assign cnt_a_m1 = cnt_a_reg - CNT_W'(1);
    assign cnt_b_m1 = cnt_b_reg - CNT_W'(1);
    assign last_a   = cnt_a_m1[IDX_W-1:0];
    assign last_b   = cnt_b_m1[IDX_W-1:0];
    assign last_e   = edge_sel_reg ? last_b : last_a;
    assign last_v   = proj_sel_reg ? last_b : last_a;
    assign p_idx    = (k_reg == '0) ? last_e : k_reg - IDX_W'(1);

    always_comb begin
        priority case (1'b1)
            state_reg == ST_RD_P: begin
                rd_addr = p_idx;
                rd_sel  = edge_sel_reg;
            end
            state_reg == ST_RD_Q: begin
                rd_addr = k_reg;
                rd_sel  = edge_sel_reg;
            end
            default: begin
                rd_addr = v_reg;
                rd_sel  = proj_sel_reg;
            end
        endcase
    end

    assign rdata = rsel_reg ? rdata_b_reg : rdata_a_reg;
    assign rd_x  = rdata[CW-1:0];
    assign rd_y  = rdata[ENTRY_W-1:CW];

    assign mul_a = (state_reg == ST_MUL_X) ? rd_x : rd_y;
    assign mul_b = (state_reg == ST_MUL_X) ? ax_reg : ay_reg;
    assign mul_p = PRW'(mul_a) * PRW'(mul_b);

    assign first_v   = (v_reg == '0);
    assign separated = (max_a_reg < min_b_reg) || (min_a_reg > max_b_reg);

    always_ff @(posedge aclk) begin
        if (wr_a) begin
            mem_a[cnt_a_reg[IDX_W-1:0]] <= s_entry;
        end
        if (wr_b) begin
            mem_b[cnt_b_reg[IDX_W-1:0]] <= s_entry;
        end
        rdata_a_reg <= mem_a[rd_addr];
        rdata_b_reg <= mem_b[rd_addr];
        rsel_reg    <= rd_sel;
    end

    always_comb begin
        state_next      = state_reg;
        cnt_a_next      = cnt_a_reg;
        cnt_b_next      = cnt_b_reg;
        ovf_next        = ovf_reg;
        edge_sel_next   = edge_sel_reg;
        proj_sel_next   = proj_sel_reg;
        k_next          = k_reg;
        v_next          = v_reg;
        px_next         = px_reg;
        py_next         = py_reg;
        ax_next         = ax_reg;
        ay_next         = ay_reg;
        prod_next       = prod_reg;
        dot_next        = dot_reg;
        min_a_next      = min_a_reg;
        max_a_next      = max_a_reg;
        min_b_next      = min_b_reg;
        max_b_next      = max_b_reg;
        hit_next        = hit_reg;
        status_next     = status_reg;
        out_valid_next  = out_valid_reg;
        out_hit_next    = out_hit_reg;
        out_status_next = out_status_reg;
        wr_a            = 1'b0;
        wr_b            = 1'b0;

        if (out_valid_reg && m_tready) begin
            out_valid_next = 1'b0;
        end

        unique case (state_reg)
            ST_IDLE: begin
                if (s_beat) begin
                    unique case (s_tuser)
                        CMD_APPEND_A: begin
                            if (cnt_a_reg == CNT_W'(MAX_VERTS)) begin
                                ovf_next = 1'b1;
                            end else begin
                                wr_a       = 1'b1;
                                cnt_a_next = cnt_a_reg + CNT_W'(1);
                            end
                        end
                        CMD_APPEND_B: begin
                            if (cnt_b_reg == CNT_W'(MAX_VERTS)) begin
                                ovf_next = 1'b1;
                            end else begin
                                wr_b       = 1'b1;
                                cnt_b_next = cnt_b_reg + CNT_W'(1);
                            end
                        end
                        CMD_RUN: begin
                            hit_next = 1'b0;
                            if (ovf_reg) begin
                                status_next = STATUS_OVERFLOW;
                                state_next  = ST_FINISH;
                            end else if (cnt_a_reg == '0 || cnt_b_reg == '0) begin
                                status_next = STATUS_EMPTY;
                                state_next  = ST_FINISH;
                            end else begin
                                status_next   = STATUS_OK;
                                edge_sel_next = 1'b0;
                                k_next        = '0;
                                state_next    = ST_RD_P;
                            end
                        end
                        default: begin
                        end
                    endcase
                end
            end
            ST_RD_P: begin
                state_next = ST_RD_Q;
            end
            ST_RD_Q: begin
                px_next    = rd_x;
                py_next    = rd_y;
                state_next = ST_AXIS;
            end
            ST_AXIS: begin
                ax_next       = AXW'(py_reg) - AXW'(rd_y);
                ay_next       = AXW'(rd_x) - AXW'(px_reg);
                proj_sel_next = 1'b0;
                v_next        = '0;
                state_next    = ST_RD_V;
            end
            ST_RD_V: begin
                state_next = ST_MUL_X;
            end
            ST_MUL_X: begin
                prod_next  = mul_p;
                state_next = ST_MUL_Y;
            end
            ST_MUL_Y: begin
                dot_next   = DOTW'(prod_reg) + DOTW'(mul_p);
                state_next = ST_CMP;
            end
            ST_CMP: begin
                if (!proj_sel_reg) begin
                    if (first_v || dot_reg < min_a_reg) min_a_next = dot_reg;
                    if (first_v || dot_reg > max_a_reg) max_a_next = dot_reg;
                end else begin
                    if (first_v || dot_reg < min_b_reg) min_b_next = dot_reg;
                    if (first_v || dot_reg > max_b_reg) max_b_next = dot_reg;
                end
                if (v_reg == last_v) begin
                    if (!proj_sel_reg) begin
                        proj_sel_next = 1'b1;
                        v_next        = '0;
                        state_next    = ST_RD_V;
                    end else begin
                        state_next = ST_TEST;
                    end
                end else begin
                    v_next     = v_reg + IDX_W'(1);
                    state_next = ST_RD_V;
                end
            end
            ST_TEST: begin
                if (separated) begin
                    hit_next   = 1'b0;
                    state_next = ST_FINISH;
                end else if (k_reg == last_e) begin
                    if (!edge_sel_reg) begin
                        edge_sel_next = 1'b1;
                        k_next        = '0;
                        state_next    = ST_RD_P;
                    end else begin
                        hit_next   = 1'b1;
                        state_next = ST_FINISH;
                    end
                end else begin
                    k_next     = k_reg + IDX_W'(1);
                    state_next = ST_RD_P;
                end
            end
            ST_FINISH: begin
                if (!out_valid_reg || m_tready) begin
                    out_valid_next  = 1'b1;
                    out_hit_next    = hit_reg;
                    out_status_next = status_reg;
                    cnt_a_next      = '0;
                    cnt_b_next      = '0;
                    ovf_next        = 1'b0;
                    state_next      = ST_IDLE;
                end
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg      <= ST_IDLE;
            cnt_a_reg      <= '0;
            cnt_b_reg      <= '0;
            ovf_reg        <= 1'b0;
            out_valid_reg  <= 1'b0;
        end else begin
            state_reg      <= state_next;
            cnt_a_reg      <= cnt_a_next;
            cnt_b_reg      <= cnt_b_next;
            ovf_reg        <= ovf_next;
            out_valid_reg  <= out_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        edge_sel_reg   <= edge_sel_next;
        proj_sel_reg   <= proj_sel_next;
        k_reg          <= k_next;
        v_reg          <= v_next;
        px_reg         <= px_next;
        py_reg         <= py_next;
        ax_reg         <= ax_next;
        ay_reg         <= ay_next;
        prod_reg       <= prod_next;
        dot_reg        <= dot_next;
        min_a_reg      <= min_a_next;
        max_a_reg      <= max_a_next;
        min_b_reg      <= min_b_next;
        max_b_reg      <= max_b_next;
        hit_reg        <= hit_next;
        status_reg     <= status_next;
        out_hit_reg    <= out_hit_next;
        out_status_reg <= out_status_next;
    end

endmodule

// File: rtl/cpsat_checker.sv
// Port-level checks for the separating-axis intersection block, bound to its top level.
// Depends on cpsat_pkg.
module cpsat_checker (
    input logic                          aclk,
    input logic                          aresetn,
    input logic                          s_tvalid,
    input logic                          s_tready,
    input logic [cpsat_pkg::S_USER_W-1:0] s_tuser,
    input logic                          m_tvalid,
    input logic                          m_tready,
    input logic [cpsat_pkg::M_DATA_W-1:0] m_tdata,
    input logic [cpsat_pkg::M_USER_W-1:0] m_tuser
);
    import cpsat_pkg::*;

    a_out_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata) && $stable(m_tuser))
        else $error("result beat changed while stalled");

    a_hit_only_ok: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid |-> !m_tdata[0] || m_tuser == STATUS_OK)
        else $error("intersects set with error status");

    a_status_code: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid |-> m_tuser == STATUS_OK || m_tuser == STATUS_EMPTY
                     || m_tuser == STATUS_OVERFLOW)
        else $error("status code out of range");

    a_run_busy: assert property (@(posedge aclk) disable iff (!aresetn)
        s_tvalid && s_tready && s_tuser == CMD_RUN |=> !s_tready)
        else $error("input taken right after a run beat");

    a_reset_empty: assert property (@(posedge aclk)
        !aresetn |=> !m_tvalid)
        else $error("result valid after reset");

endmodule

bind convex_polygon_sat_intersect cpsat_checker u_cpsat_checker (.*);
